// ===== src/tcp_rtx_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_rtx_pkg
// Shared types, codes and sizes of the TCP retransmission tracker.
// ----------------------------------------------------------------------------
package tcp_rtx_pkg;

   localparam int SLOTS   = 8;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FREED_W = $clog2(SLOTS + 1);
   localparam int ADDR_W  = 4;

   localparam logic [15:0] WINDOW_RESET = 16'hFFFF;

   // commands
   localparam logic [1:0] CMD_OPEN = 2'd0;
   localparam logic [1:0] CMD_SEND = 2'd1;
   localparam logic [1:0] CMD_ACK  = 2'd2;
   localparam logic [1:0] CMD_TICK = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_ACCEPTED    = 3'd0;
   localparam logic [2:0] KIND_WINDOW_FULL = 3'd1;
   localparam logic [2:0] KIND_TABLE_FULL  = 3'd2;
   localparam logic [2:0] KIND_ACK_DONE    = 3'd3;
   localparam logic [2:0] KIND_RETRANSMIT  = 3'd4;
   localparam logic [2:0] KIND_GIVE_UP     = 3'd5;
   localparam logic [2:0] KIND_OPENED      = 3'd6;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_RTO_BASE    = 2'd0;
   localparam logic [1:0] REG_RTO_MAX     = 2'd1;
   localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] start_seq;
      logic [15:0] seg_len;
      logic [31:0] ack_num;
      logic [15:0] adv_window;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  slot;
      logic [31:0] seq;
      logic [15:0] out_len;
      logic [3:0]  retry_count;
      logic [3:0]  freed_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [5:0] rto_base;
      logic [7:0] rto_max;
      logic [3:0] retry_limit;
   } cfg_type;

endpackage

// ===== src/tcp_retransmit_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tcp_retransmit_tracker_unit
// Tracks unacknowledged TCP segments in a small slot table, one command at a
// time. A single 32-bit subtractor, shared under a sequencer, does every
// serial-number and elapsed-time compare, one slot per cycle. Open and send
// give one result each; an ack scans every slot, then checks the send base,
// then gives one result; a tick scans every slot, then gives one result per
// expired slot, and gives no result when nothing expired. A finished
// result sits in an output register; the sequencer stalls only when that
// register is still full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module tcp_retransmit_tracker_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tcp_rtx_pkg::req_type      req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tcp_rtx_pkg::rsp_type      rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [tcp_rtx_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import tcp_rtx_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_OPEN      = 4'd1;
   localparam logic [3:0] ST_SEND      = 4'd2;
   localparam logic [3:0] ST_ACK_SCAN  = 4'd3;
   localparam logic [3:0] ST_ACK_BASE  = 4'd4;
   localparam logic [3:0] ST_ACK_DONE  = 4'd5;
   localparam logic [3:0] ST_TICK_SCAN = 4'd6;
   localparam logic [3:0] ST_TICK_FIND = 4'd7;
   localparam logic [3:0] ST_TICK_EMIT = 4'd8;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   cfg_type cfg;

   // control
   logic [3:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  exp_ff, exp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       next_seq_ff, next_seq_in;
   logic [31:0]       send_base_ff, send_base_in;
   logic [15:0]       window_ff, window_in;
   logic [31:0]       tick_ff, tick_in;

   // payload
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [FREED_W-1:0] freed_ff, freed_in;
   logic               base_ok_ff, base_ok_in;
   logic [31:0]        seq_ff   [SLOTS];
   logic [31:0]        seq_in   [SLOTS];
   logic [15:0]        len_ff   [SLOTS];
   logic [15:0]        len_in   [SLOTS];
   logic [31:0]        end_ff   [SLOTS];
   logic [31:0]        end_in   [SLOTS];
   logic [31:0]        sent_ff  [SLOTS];
   logic [31:0]        sent_in  [SLOTS];
   logic [3:0]         retry_ff [SLOTS];
   logic [3:0]         retry_in [SLOTS];

   // shared subtractor
   logic [31:0] op_a, op_b, diff;
   logic        diff_after;

   logic        out_free;
   logic [20:0] rto_shift;
   logic [20:0] rto;
   logic [SLOT_W-1:0] free_idx, exp_idx;
   logic        free_any, exp_any;
   logic [31:0] seq_sum;

   tcp_rtx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         ST_SEND: begin
            op_a = next_seq_ff;
            op_b = send_base_ff;
         end
         ST_ACK_SCAN: begin
            op_a = req_ff.ack_num;
            op_b = end_ff[idx_ff];
         end
         ST_ACK_BASE: begin
            op_a = req_ff.ack_num;
            op_b = send_base_ff;
         end
         ST_ACK_DONE: begin
            op_a = req_ff.ack_num;
            op_b = next_seq_ff;
         end
         ST_TICK_SCAN: begin
            op_a = tick_ff;
            op_b = sent_ff[idx_ff];
         end
         default: begin
            op_a = 32'd0;
            op_b = 32'd0;
         end
      endcase
   end

   assign diff       = op_a - op_b;
   // b strictly before a in serial order
   assign diff_after = (diff != 32'd0) && !diff[31];

   assign rto_shift = 21'(cfg.rto_base) << retry_ff[idx_ff];
   assign rto       = (rto_shift > 21'(cfg.rto_max)) ? 21'(cfg.rto_max) : rto_shift;
   assign seq_sum   = next_seq_ff + 32'(req_ff.seg_len);

   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      exp_idx  = '0;
      exp_any  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = SLOT_W'(i);
            free_any = 1'b1;
         end
         if (exp_ff[i]) begin
            exp_idx = SLOT_W'(i);
            exp_any = 1'b1;
         end
      end
   end

   always_comb begin
      logic [SLOTS-1:0] exp_rest;
      logic             ns_before;

      state_in     = state_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      next_seq_in  = next_seq_ff;
      send_base_in = send_base_ff;
      window_in    = window_ff;
      tick_in      = tick_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      freed_in     = freed_ff;
      base_ok_in   = base_ok_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      end_in       = end_ff;
      sent_in      = sent_ff;
      retry_in     = retry_ff;
      exp_rest     = exp_ff;
      exp_rest[idx_ff] = 1'b0;
      ns_before    = diff_after;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               freed_in = '0;
               case (req_data.cmd)
                  CMD_OPEN: state_in = ST_OPEN;
                  CMD_SEND: state_in = ST_SEND;
                  CMD_ACK: begin
                     window_in = req_data.adv_window;
                     state_in  = ST_ACK_SCAN;
                  end
                  default: begin
                     tick_in  = tick_ff + 32'd1;
                     exp_in   = '0;
                     state_in = ST_TICK_SCAN;
                  end
               endcase
            end
         end

         ST_OPEN: begin
            if (out_free) begin
               next_seq_in  = req_ff.start_seq;
               send_base_in = req_ff.start_seq;
               valid_in     = '0;
               rsp_in       = '0;
               rsp_in.kind  = KIND_OPENED;
               rsp_in.seq   = req_ff.start_seq;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_SEND: begin
            if (out_free) begin
               rsp_in         = '0;
               rsp_in.seq     = next_seq_ff;
               rsp_in.out_len = req_ff.seg_len;
               rsp_in.last    = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
               if (diff >= 32'(window_ff)) begin
                  rsp_in.kind = KIND_WINDOW_FULL;
               end else if (!free_any) begin
                  rsp_in.kind = KIND_TABLE_FULL;
               end else begin
                  rsp_in.kind        = KIND_ACCEPTED;
                  rsp_in.slot        = 3'(free_idx);
                  valid_in[free_idx] = 1'b1;
                  seq_in[free_idx]   = next_seq_ff;
                  len_in[free_idx]   = req_ff.seg_len;
                  end_in[free_idx]   = seq_sum;
                  sent_in[free_idx]  = tick_ff;
                  retry_in[free_idx] = 4'd0;
                  next_seq_in        = seq_sum;
               end
            end
         end

         ST_ACK_SCAN: begin
            // covered when the ack lies at or after the segment end
            if (valid_ff[idx_ff] && !diff[31]) begin
               valid_in[idx_ff] = 1'b0;
               freed_in         = freed_ff + FREED_W'(1);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_ACK_BASE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         ST_ACK_BASE: begin
            base_ok_in = diff_after;
            state_in   = ST_ACK_DONE;
         end

         ST_ACK_DONE: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.kind        = KIND_ACK_DONE;
               rsp_in.freed_count = 4'(freed_ff);
               rsp_in.last        = 1'b1;
               if (base_ok_ff && !ns_before) begin
                  send_base_in = req_ff.ack_num;
                  rsp_in.seq   = req_ff.ack_num;
               end else begin
                  rsp_in.seq   = send_base_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_TICK_SCAN: begin
            exp_in[idx_ff] = valid_ff[idx_ff] && !(diff < 32'(rto));
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TICK_FIND;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         ST_TICK_FIND: begin
            if (exp_any) begin
               idx_in   = exp_idx;
               state_in = ST_TICK_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_TICK_EMIT: begin
            if (out_free) begin
               exp_in[idx_ff] = 1'b0;
               rsp_in         = '0;
               rsp_in.slot    = 3'(idx_ff);
               rsp_in.seq     = seq_ff[idx_ff];
               rsp_in.out_len = len_ff[idx_ff];
               rsp_in.last    = (exp_rest == '0);
               if (retry_ff[idx_ff] >= cfg.retry_limit) begin
                  valid_in[idx_ff]   = 1'b0;
                  rsp_in.kind        = KIND_GIVE_UP;
                  rsp_in.retry_count = retry_ff[idx_ff];
               end else begin
                  retry_in[idx_ff]   = retry_ff[idx_ff] + 4'd1;
                  sent_in[idx_ff]    = tick_ff;
                  rsp_in.kind        = KIND_RETRANSMIT;
                  rsp_in.retry_count = retry_ff[idx_ff] + 4'd1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_TICK_FIND;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         exp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         next_seq_ff  <= 32'd0;
         send_base_ff <= 32'd0;
         window_ff    <= WINDOW_RESET;
         tick_ff      <= 32'd0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
         next_seq_ff  <= next_seq_in;
         send_base_ff <= send_base_in;
         window_ff    <= window_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      freed_ff   <= freed_in;
      base_ok_ff <= base_ok_in;
      seq_ff     <= seq_in;
      len_ff     <= len_in;
      end_ff     <= end_in;
      sent_ff    <= sent_in;
      retry_ff   <= retry_in;
   end

endmodule

// ===== src/tcp_rtx_csr.sv =====
// ----------------------------------------------------------------------------
// tcp_rtx_csr
// APB-style register block holding the retransmission timer settings.
// ----------------------------------------------------------------------------
module tcp_rtx_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [tcp_rtx_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output tcp_rtx_pkg::cfg_type      cfg
);
   import tcp_rtx_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RTO_BASE:    cfg_in.rto_base    = pwdata[5:0];
            REG_RTO_MAX:     cfg_in.rto_max     = pwdata[7:0];
            REG_RETRY_LIMIT: cfg_in.retry_limit = pwdata[3:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RTO_BASE:    prdata = {26'd0, cfg_ff.rto_base};
         REG_RTO_MAX:     prdata = {24'd0, cfg_ff.rto_max};
         REG_RETRY_LIMIT: prdata = {28'd0, cfg_ff.retry_limit};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rto_base    <= 6'd1;
         cfg_ff.rto_max     <= 8'd60;
         cfg_ff.retry_limit <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/tcp_rtx_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_rtx_checker
// Port-level checks on the retransmission tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tcp_rtx_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tcp_rtx_pkg::rsp_type rsp_data,
   input logic                 pready
);
   import tcp_rtx_pkg::*;

   // a held result must not change under back-pressure
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one command at a time: no new transaction straight after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // single-result commands always close their transaction
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ACCEPTED || rsp_data.kind == KIND_WINDOW_FULL ||
                    rsp_data.kind == KIND_TABLE_FULL || rsp_data.kind == KIND_ACK_DONE ||
                    rsp_data.kind == KIND_OPENED) |-> rsp_data.last)
      else $error("single-result transaction without last");

   // out of reset: nothing pending and ready for a command
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("tracker not quiet after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port stalled");

endmodule

bind tcp_retransmit_tracker_unit tcp_rtx_checker u_tcp_rtx_checker (.*);

// ===== test/tcp_retransmit_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_retransmit_tracker_unit_tb
// Self-checking bench for the retransmission tracker. Commands go in through a
// backlog queue; a behavioural copy of the slot table works out the results of
// each accepted transaction, and every result transaction is checked in order.
// Timeout settings change between phases, only while the tracker is idle.
// ----------------------------------------------------------------------------
module tcp_retransmit_tracker_unit_tb;
   import tcp_rtx_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE       = 40;   // covers a tick scan that gives nothing
   localparam int PHASE_ITEMS  = 62;
   localparam int LONG_HOLD    = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   tcp_retransmit_tracker_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the tracker
   logic [5:0]  cfg_rto_init    = 6'd1;
   logic [7:0]  cfg_rto_max     = 8'd60;
   logic [3:0]  cfg_retry_limit = 4'd5;
   logic        trk_valid   [SLOTS] = '{default: 1'b0};
   logic [31:0] trk_seq     [SLOTS] = '{default: 32'd0};
   logic [15:0] trk_len     [SLOTS] = '{default: 16'd0};
   logic [31:0] trk_sent    [SLOTS] = '{default: 32'd0};
   logic [3:0]  trk_retries [SLOTS] = '{default: 4'd0};
   logic [31:0] trk_next_seq  = 32'd0;
   logic [31:0] trk_send_base = 32'd0;
   logic [15:0] trk_window    = WINDOW_RESET;
   logic [31:0] trk_ticks     = 32'd0;

   req_type     cmd_backlog  [$];
   rsp_type     owed_results [$];
   rsp_type     want_rsp;
   int          n_bad = 0;
   int          cycle_count = 0;

   int          tx_wait = 0;
   int          tx_burst = 0;
   int unsigned tx_roll;
   int          rx_left = 0;
   logic        rx_on = 1'b0;
   int unsigned rx_roll;
   int          rx_hold_req = 0;
   int          rx_hold_seen = 0;

   cfg_type phase_cfg [7] = '{
      '{6'd60, 8'd255, 4'd15},
      '{6'd1,  8'd1,   4'd0},
      '{6'd0,  8'd255, 4'd3},   // zero timeout: every live slot fires each tick
      '{6'd5,  8'd0,   4'd2},
      '{6'd2,  8'd8,   4'd15},
      '{6'd63, 8'd255, 4'd1},
      '{6'd3,  8'd20,  4'd4}
   };

   function automatic void compute_tracker_results(input req_type r);
      rsp_type     res [$];
      rsp_type     e;
      logic [31:0] rto, elapsed, gap, d_base, d_next;
      logic [3:0]  freed;
      int          free_idx, i;
      e = '0;
      case (r.cmd)
         CMD_OPEN: begin
            trk_next_seq = r.start_seq;
            trk_send_base = r.start_seq;
            for (i = 0; i < SLOTS; i++) trk_valid[i] = 1'b0;
            e.kind = KIND_OPENED;
            e.seq = r.start_seq;
            res.push_back(e);
         end
         CMD_SEND: begin
            free_idx = -1;
            for (i = SLOTS - 1; i >= 0; i--) if (!trk_valid[i]) free_idx = i;
            e.seq = trk_next_seq;
            e.out_len = r.seg_len;
            gap = trk_next_seq - trk_send_base;
            if (gap >= {16'd0, trk_window}) begin
               e.kind = KIND_WINDOW_FULL;
            end else if (free_idx < 0) begin
               e.kind = KIND_TABLE_FULL;
            end else begin
               trk_valid[free_idx] = 1'b1;
               trk_seq[free_idx] = trk_next_seq;
               trk_len[free_idx] = r.seg_len;
               trk_sent[free_idx] = trk_ticks;
               trk_retries[free_idx] = 4'd0;
               e.kind = KIND_ACCEPTED;
               e.slot = 3'(free_idx);
               trk_next_seq = trk_next_seq + {16'd0, r.seg_len};
            end
            res.push_back(e);
         end
         CMD_ACK: begin
            trk_window = r.adv_window;
            freed = 4'd0;
            for (i = 0; i < SLOTS; i++) begin
               if (trk_valid[i]) begin
                  gap = r.ack_num - (trk_seq[i] + {16'd0, trk_len[i]});
                  if (gap < 32'h8000_0000) begin
                     trk_valid[i] = 1'b0;
                     freed = freed + 4'd1;
                  end
               end
            end
            // base moves only if the ack is past it and not past next_seq
            d_base = r.ack_num - trk_send_base;
            d_next = r.ack_num - trk_next_seq;
            if (d_base != 0 && d_base < 32'h8000_0000 &&
                !(d_next != 0 && d_next < 32'h8000_0000))
               trk_send_base = r.ack_num;
            e.kind = KIND_ACK_DONE;
            e.seq = trk_send_base;
            e.freed_count = freed;
            res.push_back(e);
         end
         default: begin
            trk_ticks = trk_ticks + 32'd1;
            for (i = 0; i < SLOTS; i++) begin
               if (trk_valid[i]) begin
                  rto = {26'd0, cfg_rto_init} << trk_retries[i];
                  if (rto > {24'd0, cfg_rto_max}) rto = {24'd0, cfg_rto_max};
                  elapsed = trk_ticks - trk_sent[i];
                  if (elapsed >= rto) begin
                     e = '0;
                     e.slot = 3'(i);
                     e.seq = trk_seq[i];
                     e.out_len = trk_len[i];
                     if (trk_retries[i] >= cfg_retry_limit) begin
                        trk_valid[i] = 1'b0;
                        e.kind = KIND_GIVE_UP;
                     end else begin
                        trk_retries[i] = trk_retries[i] + 4'd1;
                        trk_sent[i] = trk_ticks;
                        e.kind = KIND_RETRANSMIT;
                     end
                     e.retry_count = trk_retries[i];
                     res.push_back(e);
                  end
               end
            end
         end
      endcase
      if (res.size() != 0) res[res.size() - 1].last = 1'b1;
      foreach (res[k]) owed_results.push_back(res[k]);
   endfunction

   // fields a command does not use carry random noise
   function automatic req_type mk_req(input logic [1:0] cmd, input logic [31:0] a,
                                      input logic [15:0] b);
      req_type r;
      r.cmd = cmd;
      r.start_seq = $urandom();
      r.seg_len = 16'($urandom());
      r.ack_num = $urandom();
      r.adv_window = 16'($urandom());
      case (cmd)
         CMD_OPEN: r.start_seq = a;
         CMD_SEND: r.seg_len = a[15:0];
         CMD_ACK: begin
            r.ack_num = a;
            r.adv_window = b;
         end
         default: ;
      endcase
      return r;
   endfunction

   // mostly sane traffic aimed at the current send window
   function automatic req_type plan_item();
      int unsigned pick, sub;
      logic [31:0] span, val;
      logic [15:0] win;
      pick = $urandom_range(99, 0);
      sub = $urandom_range(99, 0);
      span = trk_next_seq - trk_send_base;
      if (pick < 3) begin
         val = (sub < 25) ? 32'hFFFF_0000 + $urandom_range(65535, 0) : $urandom();
         return mk_req(CMD_OPEN, val, 16'd0);
      end else if (pick < 43) begin
         if (sub < 10) val = 32'd0;
         else if (sub < 85) val = $urandom_range(1500, 1);
         else if (sub < 95) val = $urandom_range(65535, 30000);
         else val = 32'd65535;
         return mk_req(CMD_SEND, val, 16'd0);
      end else if (pick < 65) begin
         if (sub < 70) val = trk_send_base + $urandom_range(span, 0);
         else if (sub < 85) val = $urandom();
         else val = trk_send_base - $urandom_range(2000, 1);
         sub = $urandom_range(99, 0);
         if (sub < 65) win = 16'($urandom_range(65535, 4000));
         else if (sub < 80) win = 16'($urandom_range(600, 0));
         else if (sub < 90) win = 16'hFFFF;
         else win = 16'd0;
         return mk_req(CMD_ACK, val, win);
      end
      return mk_req(CMD_TICK, 32'd0, 16'd0);
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) compute_tracker_results(req_data);
         if (!req_valid || req_ready) begin
            if (tx_wait == 0 && cmd_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= cmd_backlog.pop_front();
               tx_roll = $urandom_range(99, 0);
               if (tx_burst != 0) begin
                  tx_burst--;
                  tx_wait = 0;
               end else if (tx_roll < 3) tx_burst = 40;
               else if (tx_roll < 50) tx_wait = 0;
               else if (tx_roll < 90) tx_wait = $urandom_range(3, 1);
               else if (tx_roll < 97) tx_wait = $urandom_range(12, 4);
               else tx_wait = $urandom_range(60, 20);
            end else begin
               req_valid <= 1'b0;
               if (tx_wait != 0) tx_wait--;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (rx_hold_seen != rx_hold_req) begin
         rx_hold_seen = rx_hold_req;
         rx_left = LONG_HOLD;
         rx_on = 1'b0;
         rsp_ready <= 1'b0;
      end else if (rx_left != 0) begin
         rx_left--;
         rsp_ready <= rx_on;
      end else begin
         rx_roll = $urandom_range(99, 0);
         if (rx_roll < 60) begin
            rx_on = 1'b1;
            rx_left = $urandom_range(30, 1);
         end else if (rx_roll < 68) begin
            rx_on = 1'b1;
            rx_left = $urandom_range(150, 60);
         end else if (rx_roll < 94) begin
            rx_on = 1'b0;
            rx_left = $urandom_range(3, 1);
         end else begin
            rx_on = 1'b0;
            rx_left = $urandom_range(50, 10);
         end
         rsp_ready <= rx_on;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (owed_results.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
               $display("%0t: unexpected result kind=%0d seq=%h", $realtime,
                        rsp_data.kind, rsp_data.seq);
         end else begin
            want_rsp = owed_results.pop_front();
            if (rsp_data !== want_rsp) begin
               n_bad++;
               if (n_bad <= 10) begin
                  $display("%0t: exp kind=%0d slot=%0d seq=%h len=%0d rty=%0d frd=%0d lst=%0d",
                           $realtime, want_rsp.kind, want_rsp.slot, want_rsp.seq,
                           want_rsp.out_len, want_rsp.retry_count, want_rsp.freed_count,
                           want_rsp.last);
                  $display("%0t: got kind=%0d slot=%0d seq=%h len=%0d rty=%0d frd=%0d lst=%0d",
                           $realtime, rsp_data.kind, rsp_data.slot, rsp_data.seq,
                           rsp_data.out_len, rsp_data.retry_count, rsp_data.freed_count,
                           rsp_data.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tcp_retransmit_tracker_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_backlog.size() != 0 || req_valid || owed_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_RTO_BASE:    cfg_rto_init = value[5:0];
         REG_RTO_MAX:     cfg_rto_max = value[7:0];
         REG_RETRY_LIMIT: cfg_retry_limit = value[3:0];
         default: ;
      endcase
   endtask

   initial begin
      int p, k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: sequence wrap, zero length, window and table limits
      cmd_backlog.push_back(mk_req(CMD_OPEN, 32'hFFFF_FFF0, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_SEND, 32'd0, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_SEND, 32'd16, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_SEND, 32'd65535, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_ACK, 32'h0000_0010, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_SEND, 32'd5, 16'd0));
      cmd_backlog.push_back(mk_req(CMD_ACK, 32'h0000_0000, 16'hFFFF));   // stale ack
      cmd_backlog.push_back(mk_req(CMD_SEND, 32'd5, 16'd0));             // in flight just under window
      cmd_backlog.push_back(mk_req(CMD_ACK, 32'h0001_000F, 16'hFFFF));
      for (k = 0; k < 9; k++) cmd_backlog.push_back(mk_req(CMD_SEND, 32'd100, 16'd0));
      for (k = 0; k < 4; k++) cmd_backlog.push_back(mk_req(CMD_TICK, 32'd0, 16'd0));
      wait_idle();

      for (p = 0; p < 7; p++) begin
         csr_write(REG_RTO_BASE, {26'd0, phase_cfg[p].rto_base});
         csr_write(REG_RTO_MAX, {24'd0, phase_cfg[p].rto_max});
         csr_write(REG_RETRY_LIMIT, {28'd0, phase_cfg[p].retry_limit});
         if (p == 2) rx_hold_req++;
         cmd_backlog.push_back(mk_req(CMD_OPEN, $urandom(), 16'd0));
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // short backlog keeps the shadow state close to what is being sent
            while (cmd_backlog.size() >= 3) @(posedge clock);
            cmd_backlog.push_back(plan_item());
         end
         wait_idle();
      end

      if (n_bad == 0 && owed_results.size() == 0) begin
         $display("tcp_retransmit_tracker_unit_tb: PASS");
      end else begin
         $display("tcp_retransmit_tracker_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
